>>> src/button_press_classifier_defines.svh
// Assertion helpers shared by the classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/bpc_pkg.sv
package bpc_pkg;

   localparam int TIME_W  = 32;
   localparam int MS_W    = 16;
   localparam int EVENT_W = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET   = 16'd10;
   localparam logic [MS_W-1:0] LONG_PRESS_MS_RESET = 16'd1000;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_BOUNCING  = 3'd1,
      ST_PRESSED   = 3'd2,
      ST_LONG_HELD = 3'd3,
      ST_RELEASING = 3'd4
   } state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   typedef struct packed {
      logic              raw_level;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] press_event;
   } rsp_type;

endpackage

>>> src/bpc_stream_if.sv
interface bpc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/button_press_classifier.sv
// Button press classifier: each request carries one sample of an active-low
// button pin and the current free-running millisecond time. A five-state
// machine debounces the pin and, when a release is confirmed, returns a short
// or long press event; every other request returns "no event", so there is
// exactly one response per request. The block accepts one request per clock
// while the response is not stalled, passing it through an input register and
// a result register; a stalled response holds while the input register keeps
// taking one more request. Thresholds come from two 16-bit registers written
// through the csr_ port (index 0 debounce time, index 1 long-press time) and
// should be changed only while no request is in flight.
`include "button_press_classifier_defines.svh"

module button_press_classifier
   import bpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   bpc_stream_if.sink             req_if,
   bpc_stream_if.source           rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MS_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [MS_W-1:0] debounce_ms_ff, debounce_ms_in;
   logic [MS_W-1:0] long_press_ms_ff, long_press_ms_in;

   // Input register stage.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;

   // Result register stage.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Classifier state.
   state_type         state_ff, state_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic [TIME_W-1:0] level_change_ff, level_change_in;

   logic              req_fire;
   logic              advance;
   logic              pressed;
   logic [TIME_W-1:0] since_change;
   logic [TIME_W-1:0] since_press;
   logic              debounce_reached;
   logic              debounce_within;
   logic              long_reached;
   event_type         event_in;

   // The input register moves on whenever the result register is empty or
   // is being drained in this cycle; the state machine steps exactly then.
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_fire = req_if.valid && req_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Elapsed times are wrapping 32-bit differences, compared unsigned
   // against the zero-extended thresholds.
   assign pressed      = !s1_data_ff.raw_level;
   assign since_change = s1_data_ff.time_ms - level_change_ff;
   assign since_press  = s1_data_ff.time_ms - press_start_ff;
   assign debounce_reached = since_change >= {{(TIME_W-MS_W){1'b0}}, debounce_ms_ff};
   assign debounce_within  = since_change <= {{(TIME_W-MS_W){1'b0}}, debounce_ms_ff};
   assign long_reached     = since_press  >= {{(TIME_W-MS_W){1'b0}}, long_press_ms_ff};

   // Next state and timestamps.
   always_comb begin
      state_in        = state_ff;
      press_start_in  = press_start_ff;
      level_change_in = level_change_ff;
      if (advance) begin
         case (state_ff)
            ST_IDLE: begin
               if (pressed) begin
                  state_in        = ST_BOUNCING;
                  level_change_in = s1_data_ff.time_ms;
               end
            end
            ST_BOUNCING: begin
               // A release seen after the debounce time has passed leaves the
               // machine bouncing with both timestamps untouched.
               if (pressed && debounce_reached) begin
                  state_in       = ST_PRESSED;
                  press_start_in = s1_data_ff.time_ms;
               end else if (!pressed && debounce_within) begin
                  state_in        = ST_IDLE;
                  level_change_in = s1_data_ff.time_ms;
               end
            end
            ST_PRESSED: begin
               if (pressed && long_reached) begin
                  state_in = ST_LONG_HELD;
               end else if (!pressed) begin
                  state_in        = ST_RELEASING;
                  level_change_in = s1_data_ff.time_ms;
               end
            end
            ST_LONG_HELD: begin
               if (!pressed) begin
                  state_in        = ST_RELEASING;
                  level_change_in = s1_data_ff.time_ms;
               end
            end
            ST_RELEASING: begin
               // A press during release bounce resumes the hold; the long
               // threshold is judged from the original press time.
               if (pressed) begin
                  state_in        = long_reached ? ST_LONG_HELD : ST_PRESSED;
                  level_change_in = s1_data_ff.time_ms;
               end else if (debounce_reached) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Press event reported with the request that confirms the release.
   always_comb begin
      event_in = EV_NONE;
      case (state_ff)
         ST_RELEASING: begin
            if (!pressed && debounce_reached) begin
               event_in = long_reached ? EV_LONG : EV_SHORT;
            end
         end
         default: begin
            event_in = EV_NONE;
         end
      endcase
   end

   // Pipeline handshake and configuration next values.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_if.payload;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.press_event = event_in;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      debounce_ms_in   = debounce_ms_ff;
      long_press_ms_in = long_press_ms_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:   debounce_ms_in   = csr_wdata;
            CSR_LONG_PRESS_MS: long_press_ms_in = csr_wdata;
            default: begin
               debounce_ms_in   = debounce_ms_ff;
               long_press_ms_in = long_press_ms_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         state_ff         <= ST_IDLE;
         press_start_ff   <= '0;
         level_change_ff  <= '0;
         debounce_ms_ff   <= DEBOUNCE_MS_RESET;
         long_press_ms_ff <= LONG_PRESS_MS_RESET;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         state_ff         <= state_in;
         press_start_ff   <= press_start_in;
         level_change_ff  <= level_change_in;
         debounce_ms_ff   <= debounce_ms_in;
         long_press_ms_ff <= long_press_ms_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A press event can only come out of a confirmed release.
   `BPC_ASSERT_NOW(a_event_from_release, clock, reset,
      advance && (event_in != EV_NONE), state_ff == ST_RELEASING,
      "press event raised outside the releasing state")

   // After reporting an event the machine is back at idle.
   `BPC_ASSERT_NEXT(a_idle_after_event, clock, reset,
      advance && (event_in != EV_NONE), state_ff == ST_IDLE,
      "machine not idle after a press event")

   // The state machine only moves when a request passes to the result stage.
   `BPC_ASSERT_NEXT(a_state_holds_on_stall, clock, reset,
      !advance, $stable(state_ff) && $stable(press_start_ff) && $stable(level_change_ff),
      "classifier state changed without a request")

   // Requests are refused only when both stages are full and the output stalls.
   `BPC_ASSERT_NOW(a_ready_only_when_full, clock, reset,
      !req_if.ready, s1_valid_ff && rsp_valid_ff && !rsp_if.ready,
      "request refused while the pipeline has room")

endmodule

>>> tb/button_press_classifier_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the button press classifier. Every request carries
// one pin sample and a millisecond time stamp, and the block answers each
// request with exactly one press event. A behavioral copy of the debounce
// machine in this module predicts each event as the request is accepted.
// The checker compares every response against the oldest prediction still
// waiting.
module button_press_classifier_test
   import bpc_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned ITEMS_PER_PHASE = 238;
   localparam int unsigned PHASE_COUNT     = 6;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int          DIRECTED_COUNT  = 26;

   // One row of the directed table. When typed is set, want is the event that
   // was worked out by hand. Otherwise the predictor supplies the event.
   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] at_ms;
      logic              typed;
      event_type         want;
   } directed_row_type;

   typedef struct {
      req_type   sample;
      bit        typed;
      event_type want;
   } request_entry_type;

   // The directed walk runs with the reset thresholds: debounce 10 ms and
   // long press 1000 ms. Each group below drives the machine through one path.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Released pin straight after reset, at time zero: nothing happens.
      '{1'b1, 32'd0,          1'b1, EV_NONE},
      // A quick bounce drops back to idle, because the release comes within
      // the debounce time.
      '{1'b0, 32'd100,        1'b0, EV_NONE},
      '{1'b1, 32'd105,        1'b0, EV_NONE},
      // A late release while bouncing leaves the machine in bouncing. The
      // press that follows is then confirmed.
      '{1'b0, 32'd200,        1'b0, EV_NONE},
      '{1'b1, 32'd215,        1'b0, EV_NONE},
      '{1'b0, 32'd216,        1'b0, EV_NONE},
      // Release, one sample short of settling, then settled: a short press.
      '{1'b1, 32'd300,        1'b0, EV_NONE},
      '{1'b1, 32'd309,        1'b0, EV_NONE},
      '{1'b1, 32'd310,        1'b1, EV_SHORT},
      // The hold reaches the long-press limit exactly. A release glitch
      // returns to long held, and the final release reports a long press.
      '{1'b0, 32'd1000,       1'b0, EV_NONE},
      '{1'b0, 32'd1010,       1'b0, EV_NONE},
      '{1'b0, 32'd2010,       1'b0, EV_NONE},
      '{1'b1, 32'd2500,       1'b0, EV_NONE},
      '{1'b0, 32'd2505,       1'b0, EV_NONE},
      '{1'b1, 32'd2600,       1'b0, EV_NONE},
      '{1'b1, 32'd2610,       1'b1, EV_LONG},
      // A glitch early in the hold goes back to pressed. The release starts
      // just before the limit, but the hold time is judged when the release
      // settles, so this still counts as a long press.
      '{1'b0, 32'd3000,       1'b0, EV_NONE},
      '{1'b0, 32'd3010,       1'b0, EV_NONE},
      '{1'b1, 32'd3100,       1'b0, EV_NONE},
      '{1'b0, 32'd3105,       1'b0, EV_NONE},
      '{1'b1, 32'd4009,       1'b0, EV_NONE},
      '{1'b1, 32'd4019,       1'b1, EV_LONG},
      // The press is confirmed across the 32-bit wrap. Time then jumps back
      // to the maximum, so both elapsed times are huge.
      '{1'b0, 32'hFFFF_FFF8,  1'b0, EV_NONE},
      '{1'b0, 32'h0000_0002,  1'b0, EV_NONE},
      '{1'b1, 32'h0000_0005,  1'b0, EV_NONE},
      '{1'b1, 32'hFFFF_FFFF,  1'b1, EV_LONG}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE_MS;
   logic [MS_W-1:0]        csr_wdata = '0;

   bpc_stream_if #(.payload_type(req_type)) req_if ();
   bpc_stream_if #(.payload_type(rsp_type)) rsp_if ();

   button_press_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state and its copy of the two threshold registers.
   state_type         btn_state;
   logic [TIME_W-1:0] press_time;
   logic [TIME_W-1:0] change_time;
   logic [MS_W-1:0]   debounce_lim;
   logic [MS_W-1:0]   long_lim;

   request_entry_type samples_to_send [$];
   event_type         expected_events [$];

   int unsigned       send_gap_pct;
   int unsigned       recv_stall_pct;
   int unsigned       failures = 0;
   int unsigned       cycle_count = 0;
   int unsigned       items_queued;
   logic [TIME_W-1:0] now_ms;

   function automatic void note_failure(string what);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("[%0t] %s", $realtime, what);
   endfunction

   // Advances the debounce machine by one sample and returns the event that
   // the sample produces. All elapsed times wrap modulo 2^32 and are compared
   // unsigned against the 16-bit thresholds.
   function automatic event_type classify_sample(req_type sample);
      logic              pressed;
      logic [TIME_W-1:0] since_change;
      logic [TIME_W-1:0] held_for;
      event_type         result;
      pressed      = !sample.raw_level;
      since_change = sample.time_ms - change_time;
      held_for     = sample.time_ms - press_time;
      result       = EV_NONE;
      case (btn_state)
         ST_IDLE: begin
            if (pressed) begin
               btn_state   = ST_BOUNCING;
               change_time = sample.time_ms;
            end
         end
         ST_BOUNCING: begin
            // A release after the debounce time falls through both branches
            // and changes nothing.
            if (pressed && since_change >= debounce_lim) begin
               btn_state  = ST_PRESSED;
               press_time = sample.time_ms;
            end else if (!pressed && since_change <= debounce_lim) begin
               btn_state   = ST_IDLE;
               change_time = sample.time_ms;
            end
         end
         ST_PRESSED: begin
            if (pressed && held_for >= long_lim) begin
               btn_state = ST_LONG_HELD;
            end else if (!pressed) begin
               btn_state   = ST_RELEASING;
               change_time = sample.time_ms;
            end
         end
         ST_LONG_HELD: begin
            if (!pressed) begin
               btn_state   = ST_RELEASING;
               change_time = sample.time_ms;
            end
         end
         ST_RELEASING: begin
            if (pressed) begin
               btn_state   = (held_for < long_lim) ? ST_PRESSED : ST_LONG_HELD;
               change_time = sample.time_ms;
            end else if (since_change >= debounce_lim) begin
               result    = (held_for >= long_lim) ? EV_LONG : EV_SHORT;
               btn_state = ST_IDLE;
            end
         end
         default: btn_state = ST_IDLE;
      endcase
      return result;
   endfunction

   // Both channels are handled in one process, so the order in which requests
   // and responses are seen at an edge does not depend on the simulator. The
   // response side runs first. With its latency, the block can never answer a
   // request at the edge where it accepts it.
   always @(posedge clock) begin
      request_entry_type head;
      event_type         predicted;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
               note_failure($sformatf("response %0d arrived with no request pending",
                                      rsp_if.payload.press_event));
            end else begin
               predicted = expected_events.pop_front();
               if (rsp_if.payload.press_event !== predicted)
                  note_failure($sformatf("press_event mismatch: expected %0d, got %0d",
                                         predicted, rsp_if.payload.press_event));
            end
         end

         if (req_if.valid && req_if.ready) begin
            head      = samples_to_send.pop_front();
            predicted = classify_sample(req_if.payload);
            expected_events.push_back(head.typed ? head.want : predicted);
         end

         // An offered request stays on the bus until it is taken. Otherwise the
         // next request is offered, unless the sender idles this cycle.
         if (!(req_if.valid && !req_if.ready)) begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= samples_to_send[0].sample;
            end else begin
               req_if.valid <= 1'b0;
            end
         end

         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_request(logic level, logic [TIME_W-1:0] at_ms, bit typed,
                                event_type want);
      request_entry_type entry;
      entry.sample.raw_level = level;
      entry.sample.time_ms   = at_ms;
      entry.typed            = typed;
      entry.want             = want;
      samples_to_send.push_back(entry);
      items_queued++;
   endtask

   // Waits until every queued request is sent and every response is back,
   // then lets the pipeline settle. The queues are read on the falling edge
   // so that they are not sampled while the clocked process updates them.
   task automatic wait_for_quiet();
      while (samples_to_send.size() != 0 || expected_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one threshold register. The predictor's copy is updated at the
   // same time, which is safe because this is only called while the block is
   // idle.
   task automatic program_register(logic [CSR_INDEX_W-1:0] index, logic [MS_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_DEBOUNCE_MS)
         debounce_lim = value;
      else
         long_lim = value;
   endtask

   // Picks a duration around a threshold. The picks land below it, exactly on
   // it, just past it, or well beyond it, so that each comparison is tested
   // on both sides and at equality.
   function automatic int unsigned near_threshold(int unsigned lim);
      case ($urandom_range(0, 5))
         0:       return (lim == 0) ? 0 : lim - 1;
         1:       return lim;
         2:       return lim + 1;
         3:       return $urandom_range(0, lim);
         4:       return lim + $urandom_range(0, lim + 4);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   // Sends count samples of one pin level, spread evenly from now_ms to
   // now_ms + span. A short gap follows before the next run.
   task automatic emit_level_run(logic level, int unsigned span, int unsigned count);
      logic [TIME_W-1:0] start_ms;
      longint unsigned   offset;
      start_ms = now_ms;
      for (int unsigned i = 0; i < count; i++) begin
         offset = (count > 1) ? (longint'(span) * i) / (count - 1) : 0;
         queue_request(level, start_ms + TIME_W'(offset), 1'b0, EV_NONE);
      end
      now_ms = start_ms + span + $urandom_range(0, 2);
   endtask

   // One well-formed press, with random timing. An optional bounce on the way
   // in and an optional glitch in the hold exercise the early-release, late-
   // release and releasing-to-held paths.
   task automatic emit_press_sequence();
      emit_level_run(1'b1, near_threshold(debounce_lim), $urandom_range(1, 3));
      if ($urandom_range(0, 2) == 0) begin
         emit_level_run(1'b0, $urandom_range(0, debounce_lim), 1);
         emit_level_run(1'b1, near_threshold(debounce_lim), $urandom_range(1, 2));
      end
      emit_level_run(1'b0, near_threshold(debounce_lim), $urandom_range(1, 3));
      emit_level_run(1'b0, near_threshold(long_lim), $urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) begin
         emit_level_run(1'b1, $urandom_range(0, debounce_lim), 1);
         emit_level_run(1'b0, near_threshold(long_lim), $urandom_range(1, 3));
      end
      emit_level_run(1'b1, near_threshold(debounce_lim), $urandom_range(1, 3));
   endtask

   // Mostly well-formed presses. The rest are bursts of random levels and
   // times, including jumps to any 32-bit time.
   task automatic run_random_phase();
      items_queued = 0;
      if ($urandom_range(0, 1) == 0)
         now_ms = $urandom();
      else
         now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * long_lim + 8);
      while (items_queued < ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 99) < 80) begin
            emit_press_sequence();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 3) == 0)
                  now_ms = $urandom();
               else
                  now_ms += $urandom_range(0, 2 * debounce_lim + 2);
               queue_request(1'($urandom_range(0, 1)), now_ms, 1'b0, EV_NONE);
            end
         end
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      btn_state      = ST_IDLE;
      press_time     = '0;
      change_time    = '0;
      debounce_lim   = DEBOUNCE_MS_RESET;
      long_lim       = LONG_PRESS_MS_RESET;
      send_gap_pct   = 24;
      recv_stall_pct = 55;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[i])
         queue_request(DIRECTED_ROWS[i].level, DIRECTED_ROWS[i].at_ms,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // Each random phase starts once the block has drained completely, so
      // the sender sits idle until every response is back. The thresholds
      // cover the reset values, both extremes, and a few values in between.
      // The idle pattern changes after every second phase.
      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_quiet();
         case (phase)
            0: begin
               program_register(CSR_DEBOUNCE_MS, 16'd10);
               program_register(CSR_LONG_PRESS_MS, 16'd1000);
            end
            1: begin
               program_register(CSR_DEBOUNCE_MS, 16'd0);
               program_register(CSR_LONG_PRESS_MS, 16'd0);
            end
            2: begin
               program_register(CSR_DEBOUNCE_MS, 16'hFFFF);
               program_register(CSR_LONG_PRESS_MS, 16'hFFFF);
            end
            3: begin
               program_register(CSR_DEBOUNCE_MS, 16'd5);
               program_register(CSR_LONG_PRESS_MS, 16'd60);
            end
            4: begin
               program_register(CSR_DEBOUNCE_MS, MS_W'($urandom_range(0, 40)));
               program_register(CSR_LONG_PRESS_MS, MS_W'($urandom_range(0, 3000)));
            end
            default: begin
               program_register(CSR_DEBOUNCE_MS, 16'hFFFF);
               program_register(CSR_LONG_PRESS_MS, 16'd0);
            end
         endcase
         if (phase < 2) begin
            send_gap_pct   = 24;
            recv_stall_pct = 55;
         end else if (phase < 4) begin
            send_gap_pct   = 55;
            recv_stall_pct = 24;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         @(negedge clock);
         run_random_phase();
      end

      wait_for_quiet();
      if (expected_events.size() != 0)
         note_failure("responses still missing at end of run");
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/bpc_pkg.sv
src/bpc_stream_if.sv
src/button_press_classifier.sv
tb/button_press_classifier_test.sv
